/* rtl/core/pfda_pkg.sv */
// Package for the filtered-derivative PID block.
// Holds the datapath command codes, multiplier operand codes and shared types.
// No dependencies.
package pfda_pkg;

  localparam int unsigned SIG_W   = 32;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned ACC48_W = 48;
  localparam int unsigned HALF_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // Numerator of the derivative filter and its restoring divider.
  localparam int unsigned NUM_W     = 74;
  localparam int unsigned DEN_W     = 25;
  localparam int unsigned DIV_STEPS = NUM_W / 2;
  localparam int unsigned DCNT_W    = 6;

  // Shared multiplier and accumulator.
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned SUM_W  = 82;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU    = 3'd5;

  // Datapath actions.
  localparam logic [3:0] ACT_NONE  = 4'd0;
  localparam logic [3:0] ACT_LOAD  = 4'd1;
  localparam logic [3:0] ACT_CLEAR = 4'd2;
  localparam logic [3:0] ACT_SKIP  = 4'd3;
  localparam logic [3:0] ACT_NUM   = 4'd4;
  localparam logic [3:0] ACT_MUL   = 4'd5;
  localparam logic [3:0] ACT_ACC   = 4'd6;
  localparam logic [3:0] ACT_DIVS  = 4'd7;
  localparam logic [3:0] ACT_DIV   = 4'd8;
  localparam logic [3:0] ACT_DIVE  = 4'd9;
  localparam logic [3:0] ACT_FIN   = 4'd10;

  // Multiplier operand pairs, in the order the sequencer issues them.
  localparam logic [2:0] MS_FDLO = 3'd0;
  localparam logic [2:0] MS_FDHI = 3'd1;
  localparam logic [2:0] MS_EDT  = 3'd2;
  localparam logic [2:0] MS_GP   = 3'd3;
  localparam logic [2:0] MS_GDLO = 3'd4;
  localparam logic [2:0] MS_GDHI = 3'd5;
  localparam logic [2:0] MS_GILO = 3'd6;
  localparam logic [2:0] MS_GIHI = 3'd7;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] msel;
  } pfda_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_skip;
  } pfda_stat_t;

endpackage

/* rtl/core/pfda_if.sv */
// Handshake channel interfaces for the filtered-derivative PID block.
// Depends on nothing but the widths written here.
interface pfda_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] setpoint;
  logic [31:0] measurement;
  logic [23:0] time_step;
  modport source (output valid, op, setpoint, measurement, time_step, input ready);
  modport sink (input valid, op, setpoint, measurement, time_step, output ready);
endinterface

interface pfda_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive;
  logic [31:0] error_out;
  modport source (output valid, drive, error_out, input ready);
  modport sink (input valid, drive, error_out, output ready);
endinterface

/* rtl/core/pfda_ctrl.sv */
// Sequencer of the filtered-derivative PID block.
// Depends on pfda_pkg; drives the datapath through pfda_cmd_t.
module pfda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pfda_pkg::pfda_stat_t stat,
  output pfda_pkg::pfda_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_NUM  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_DIVS = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_DIVE = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [pfda_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    cmd.act   = pfda_pkg::ACT_NONE;
    cmd.msel  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.is_clear) begin
            cmd.act   = pfda_pkg::ACT_CLEAR;
            state_nxt = ST_OUT;
          end else if (stat.is_skip) begin
            cmd.act   = pfda_pkg::ACT_SKIP;
            state_nxt = ST_OUT;
          end else begin
            cmd.act   = pfda_pkg::ACT_LOAD;
            state_nxt = ST_NUM;
          end
        end
      end
      ST_NUM: begin
        cmd.act   = pfda_pkg::ACT_NUM;
        idx_nxt   = pfda_pkg::MS_FDLO;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.act   = pfda_pkg::ACT_MUL;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.act = pfda_pkg::ACT_ACC;
        if (idx_r == pfda_pkg::MS_FDHI) begin
          state_nxt = ST_DIVS;
        end else if (idx_r == pfda_pkg::MS_GIHI) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DIVS: begin
        cmd.act   = pfda_pkg::ACT_DIVS;
        cnt_nxt   = pfda_pkg::DCNT_W'(pfda_pkg::DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.act = pfda_pkg::ACT_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DIVE;
        end
      end
      ST_DIVE: begin
        cmd.act   = pfda_pkg::ACT_DIVE;
        idx_nxt   = pfda_pkg::MS_EDT;
        state_nxt = ST_MUL;
      end
      ST_FIN: begin
        cmd.act   = pfda_pkg::ACT_FIN;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/pfda_dp.sv */
// Datapath of the filtered-derivative PID block: configuration registers,
// controller state, shared multiplier with accumulator, radix-4 divider.
// Depends on pfda_pkg; commanded by pfda_ctrl.
module pfda_dp #(
  parameter int unsigned SIGNAL_FRAC_BITS = 16,
  parameter int unsigned TIME_FRAC_BITS   = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pfda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          in_op,
  input  logic [31:0]                   in_setpoint,
  input  logic [31:0]                   in_measurement,
  input  logic [23:0]                   in_time_step,
  input  pfda_pkg::pfda_cmd_t           cmd,
  output pfda_pkg::pfda_stat_t          stat,
  output logic [31:0]                   out_drive,
  output logic [31:0]                   out_error_out
);

  localparam int unsigned SW = pfda_pkg::SIG_W;
  localparam int unsigned AW = pfda_pkg::ACC48_W;
  localparam int unsigned HW = pfda_pkg::HALF_W;
  localparam int unsigned NW = pfda_pkg::NUM_W;
  localparam int unsigned DW = pfda_pkg::DEN_W;
  localparam int unsigned MW = pfda_pkg::MUL_W;
  localparam int unsigned PW = pfda_pkg::PROD_W;
  localparam int unsigned UW = pfda_pkg::SUM_W;

  localparam logic signed [PW-1:0] ACC_MAX = PW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [PW-1:0] ACC_MIN = -ACC_MAX - PW'(1);
  localparam logic [NW-1:0] LIM_POS = NW'({1'b0, {(AW-1){1'b1}}});
  localparam logic [NW-1:0] LIM_NEG = LIM_POS + NW'(1);

  logic signed [SW-1:0] gain_p_r, gain_i_r, gain_d_r, out_min_r, out_max_r;
  logic [23:0] tau_r;

  logic signed [SW-1:0] meas_r, err_r, prev_r, last_drive_r, last_err_r;
  logic signed [SW:0]   x_r;
  logic [23:0]          dt_r;
  logic [DW-1:0]        den_r;
  logic signed [AW-1:0] integ_r, fd_r, cand_r, deriv_r;
  logic signed [UW-1:0] acc_r;
  logic signed [PW-1:0] prod_r;
  logic [DW-1:0]        rem_r;
  logic [NW-1:0]        quo_r;
  logic                 neg_r;
  logic [31:0]          drive_r, eout_r;

  assign stat.is_clear = in_op;
  assign stat.is_skip  = (in_time_step == '0);
  assign out_drive     = drive_r;
  assign out_error_out = eout_r;

  // Input differences.
  logic signed [SW:0] diff_e, diff_x;
  logic signed [SW-1:0] err_sat;
  always_comb begin
    diff_e = {in_setpoint[SW-1], in_setpoint} - {in_measurement[SW-1], in_measurement};
    diff_x = {prev_r[SW-1], prev_r} - {in_measurement[SW-1], in_measurement};
    if (diff_e[SW] != diff_e[SW-1]) begin
      err_sat = diff_e[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      err_sat = diff_e[SW-1:0];
    end
  end

  // Multiplier operand selection.
  logic signed [MW-1:0] op_a, op_b;
  logic                 hi_sel;
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    hi_sel = 1'b0;
    case (cmd.msel)
      pfda_pkg::MS_FDLO: begin
        op_a = MW'({1'b0, fd_r[HW-1:0]});
        op_b = MW'({1'b0, tau_r});
      end
      pfda_pkg::MS_FDHI: begin
        op_a   = MW'($signed(fd_r[AW-1:HW]));
        op_b   = MW'({1'b0, tau_r});
        hi_sel = 1'b1;
      end
      pfda_pkg::MS_EDT: begin
        op_a = MW'(err_r);
        op_b = MW'({1'b0, dt_r});
      end
      pfda_pkg::MS_GP: begin
        op_a = MW'(err_r);
        op_b = MW'(gain_p_r);
      end
      pfda_pkg::MS_GDLO: begin
        op_a = MW'({1'b0, deriv_r[HW-1:0]});
        op_b = MW'(gain_d_r);
      end
      pfda_pkg::MS_GDHI: begin
        op_a   = MW'($signed(deriv_r[AW-1:HW]));
        op_b   = MW'(gain_d_r);
        hi_sel = 1'b1;
      end
      pfda_pkg::MS_GILO: begin
        op_a = MW'({1'b0, cand_r[HW-1:0]});
        op_b = MW'(gain_i_r);
      end
      default: begin
        op_a   = MW'($signed(cand_r[AW-1:HW]));
        op_b   = MW'(gain_i_r);
        hi_sel = 1'b1;
      end
    endcase
  end

  // Accumulate the registered product, shifted for the upper halves.
  logic signed [UW-1:0] prod_ext, acc_add;
  assign prod_ext = UW'(prod_r);
  assign acc_add  = acc_r + (hi_sel ? (prod_ext <<< HW) : prod_ext);

  // Integral candidate: floor(err*dt / 2^T) added to the integral, saturated.
  logic signed [PW-1:0] cand_sum;
  logic signed [AW-1:0] cand_sat;
  always_comb begin
    cand_sum = PW'(integ_r) + (prod_r >>> TIME_FRAC_BITS);
    if (cand_sum > ACC_MAX) begin
      cand_sat = ACC_MAX[AW-1:0];
    end else if (cand_sum < ACC_MIN) begin
      cand_sat = ACC_MIN[AW-1:0];
    end else begin
      cand_sat = cand_sum[AW-1:0];
    end
  end

  // Divider: two restoring steps per cycle.
  logic [NW-1:0] num_val, num_mag;
  logic [DW:0]   t1, t2;
  logic [DW-1:0] r1, r2;
  logic          q1, q2;
  always_comb begin
    num_val = acc_r[NW-1:0];
    num_mag = acc_r[NW-1] ? (~num_val + NW'(1)) : num_val;
    t1 = {rem_r, quo_r[NW-1]};
    q1 = (t1 >= {1'b0, den_r});
    r1 = q1 ? DW'(t1 - {1'b0, den_r}) : t1[DW-1:0];
    t2 = {r1, quo_r[NW-2]};
    q2 = (t2 >= {1'b0, den_r});
    r2 = q2 ? DW'(t2 - {1'b0, den_r}) : t2[DW-1:0];
  end

  logic signed [AW-1:0] deriv_fin;
  always_comb begin
    if (quo_r > (neg_r ? LIM_NEG : LIM_POS)) begin
      deriv_fin = neg_r ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else if (neg_r) begin
      deriv_fin = -quo_r[AW-1:0];
    end else begin
      deriv_fin = quo_r[AW-1:0];
    end
  end

  // Final scaling and clamp.
  logic signed [UW-1:0] sum_sh;
  logic signed [SW-1:0] drive_fin;
  logic                 in_range;
  always_comb begin
    sum_sh   = acc_r >>> SIGNAL_FRAC_BITS;
    in_range = 1'b0;
    if (sum_sh < UW'(out_min_r)) begin
      drive_fin = out_min_r;
    end else if (sum_sh > UW'(out_max_r)) begin
      drive_fin = out_max_r;
    end else begin
      drive_fin = sum_sh[SW-1:0];
      in_range  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r  <= '0;
      gain_i_r  <= '0;
      gain_d_r  <= '0;
      out_min_r <= {1'b1, {(SW-1){1'b0}}};
      out_max_r <= {1'b0, {(SW-1){1'b1}}};
      tau_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfda_pkg::CFG_GAIN_P:  gain_p_r  <= cfg_wdata;
        pfda_pkg::CFG_GAIN_I:  gain_i_r  <= cfg_wdata;
        pfda_pkg::CFG_GAIN_D:  gain_d_r  <= cfg_wdata;
        pfda_pkg::CFG_OUT_MIN: out_min_r <= cfg_wdata;
        pfda_pkg::CFG_OUT_MAX: out_max_r <= cfg_wdata;
        pfda_pkg::CFG_TAU:     tau_r     <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      fd_r         <= '0;
      prev_r       <= '0;
      last_drive_r <= '0;
      last_err_r   <= '0;
    end else if (cmd.act == pfda_pkg::ACT_CLEAR) begin
      integ_r      <= '0;
      fd_r         <= '0;
      prev_r       <= '0;
      last_drive_r <= '0;
      last_err_r   <= '0;
    end else if (cmd.act == pfda_pkg::ACT_FIN) begin
      if (in_range) begin
        integ_r <= cand_r;
      end
      fd_r         <= deriv_r;
      prev_r       <= meas_r;
      last_drive_r <= drive_fin;
      last_err_r   <= err_r;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.act)
      pfda_pkg::ACT_LOAD: begin
        meas_r <= in_measurement;
        err_r  <= err_sat;
        x_r    <= diff_x;
        dt_r   <= in_time_step;
        den_r  <= {1'b0, tau_r} + {1'b0, in_time_step};
      end
      pfda_pkg::ACT_CLEAR: begin
        drive_r <= '0;
        eout_r  <= '0;
      end
      pfda_pkg::ACT_SKIP: begin
        drive_r <= last_drive_r;
        eout_r  <= last_err_r;
      end
      pfda_pkg::ACT_NUM: begin
        acc_r <= UW'(x_r) <<< TIME_FRAC_BITS;
      end
      pfda_pkg::ACT_MUL: begin
        prod_r <= op_a * op_b;
      end
      pfda_pkg::ACT_ACC: begin
        if (cmd.msel == pfda_pkg::MS_EDT) begin
          cand_r <= cand_sat;
          acc_r  <= '0;
        end else begin
          acc_r <= acc_add;
        end
      end
      pfda_pkg::ACT_DIVS: begin
        neg_r <= acc_r[NW-1];
        quo_r <= num_mag;
        rem_r <= '0;
      end
      pfda_pkg::ACT_DIV: begin
        rem_r <= r2;
        quo_r <= {quo_r[NW-3:0], q1, q2};
      end
      pfda_pkg::ACT_DIVE: begin
        deriv_r <= deriv_fin;
      end
      pfda_pkg::ACT_FIN: begin
        drive_r <= drive_fin;
        eout_r  <= err_r;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/pid_filtered_derivative_antiwindup.sv */
// Top level of the PID step with filtered derivative and anti-windup.
// Depends on pfda_pkg, pfda_if, pfda_ctrl and pfda_dp.
//
//   channel   direction  payload                                   handshake
//   in_ch     sink       op, setpoint, measurement, time_step      valid/ready
//   out_ch    source     drive, error_out                          valid/ready
//   cfg_*     input      cfg_index, cfg_wdata                      cfg_we
//
// Once a control step is accepted, the block seeds the numerator, runs eight
// products through one shared 33x33 multiplier, each multiplied and then
// accumulated, runs the radix-4 divider for the derivative filter with a start
// and a finish step after the second product, and clamps the sum before it
// offers its result. A clear or a zero time step gives its result in the next
// cycle. One item is in flight at a time; the next is taken in the cycle after
// the result is taken. Reset is synchronous.
module pid_filtered_derivative_antiwindup #(
  parameter int unsigned SIGNAL_FRAC_BITS = 16,
  parameter int unsigned TIME_FRAC_BITS   = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pfda_in_if.sink                        in_ch,
  pfda_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pfda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  pfda_pkg::pfda_cmd_t  cmd;
  pfda_pkg::pfda_stat_t stat;

  pfda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfda_dp #(
    .SIGNAL_FRAC_BITS (SIGNAL_FRAC_BITS),
    .TIME_FRAC_BITS   (TIME_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_ch.op),
    .in_setpoint    (in_ch.setpoint),
    .in_measurement (in_ch.measurement),
    .in_time_step   (in_ch.time_step),
    .cmd            (cmd),
    .stat           (stat),
    .out_drive      (out_ch.drive),
    .out_error_out  (out_ch.error_out)
  );

endmodule
